@@ rtl/sfra_pkg.sv @@
// sfra_pkg: shared types and constants for the stream find-and-replace block
// item, result, config and job structs, register index codes, parameter defaults
// no dependencies
package sfra_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CFG_W           = 64;
    localparam int LANE_MAX        = 8;
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int REG_INDEX_W     = 2;

    localparam logic [LEN_W-1:0] PATTERN_LEN_RST = 4'd1;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PATTERN_BYTES = 2'd0,
        REG_PATTERN_LEN   = 2'd1,
        REG_REPLACE_BYTES = 2'd2,
        REG_REPLACE_LEN   = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              string_end;
        logic              last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_len;
        logic [CFG_W-1:0] replacement_bytes;
        logic [LEN_W-1:0] replacement_len;
    } t_cfg;

    // one classified request: cnt bytes from lane 0 up, then an end marker if eos
    typedef struct packed {
        logic [LANE_MAX-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                cnt;
        logic                            eos;
    } t_job;

endpackage

@@ rtl/sfra_front.sv @@
// sfra_front: window of unresolved bytes, pattern compare and job classification
// depends on sfra_pkg
module sfra_front #(
    parameter int PATTERN_MAX = sfra_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfra_pkg::REPLACE_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfra_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    input  sfra_pkg::t_in_item i_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output sfra_pkg::t_job     o_q_job
);

    localparam int LW = sfra_pkg::LEN_W;
    localparam int BW = sfra_pkg::BYTE_W;

    logic [BW-1:0] r_win [PATTERN_MAX];
    logic [BW-1:0] n_win [PATTERN_MAX];
    logic [BW-1:0] app   [PATTERN_MAX];
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] p_eff, r_eff, grown, drop, shift;
    logic          accept, match;

    assign accept = i_push && !i_q_full;

    always_comb begin
        // saturate the configured lengths; a zero pattern length acts as one
        if (i_cfg.pattern_len == '0) begin
            p_eff = LW'(1);
        end else if (i_cfg.pattern_len > LW'(PATTERN_MAX)) begin
            p_eff = LW'(PATTERN_MAX);
        end else begin
            p_eff = i_cfg.pattern_len;
        end
        if (i_cfg.replacement_len > LW'(REPLACE_MAX)) begin
            r_eff = LW'(REPLACE_MAX);
        end else begin
            r_eff = i_cfg.replacement_len;
        end

        grown = r_fill + LW'(1);
        drop  = grown - p_eff + LW'(1);

        // window with the new byte appended
        for (int i = 0; i < PATTERN_MAX; i++) begin
            app[i] = (LW'(i) == r_fill) ? i_item.in_byte : r_win[i];
        end

        match = (grown == p_eff);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (LW'(i) < p_eff && app[i] != i_cfg.pattern_bytes[BW*i +: BW]) begin
                match = 1'b0;
            end
        end

        o_q_job  = '0;
        o_q_push = 1'b0;
        n_fill   = r_fill;
        shift    = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            n_win[i] = r_win[i];
        end

        if (accept) begin
            if (i_item.end_of_string) begin
                // flush whatever is pending, then the end marker
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    o_q_job.bytes[i] = r_win[i];
                end
                o_q_job.cnt = r_fill;
                o_q_job.eos = 1'b1;
                o_q_push    = 1'b1;
                n_fill      = '0;
            end else begin
                if (match) begin
                    for (int i = 0; i < REPLACE_MAX; i++) begin
                        o_q_job.bytes[i] = i_cfg.replacement_bytes[BW*i +: BW];
                    end
                    o_q_job.cnt = r_eff;
                    o_q_push    = (r_eff != '0);
                    n_fill      = '0;
                end else if (grown >= p_eff) begin
                    // release the oldest bytes until pattern length minus one remain
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        o_q_job.bytes[i] = app[i];
                    end
                    o_q_job.cnt = drop;
                    o_q_push    = 1'b1;
                    n_fill      = p_eff - LW'(1);
                    shift       = drop;
                end else begin
                    n_fill = grown;
                end
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    n_win[i] = app[i];
                    for (int j = 0; j < PATTERN_MAX; j++) begin
                        if (j >= i && LW'(j - i) == shift) begin
                            n_win[i] = app[j];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < LW'(PATTERN_MAX))
        else $error("window fill beyond pattern capacity");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.end_of_string |=> r_fill == '0)
        else $error("end of string did not empty the window");

endmodule

@@ rtl/sfra_queue.sv @@
// sfra_queue: short job queue between the front and back parts
// depends on sfra_pkg
module sfra_queue #(
    parameter int DEPTH = sfra_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfra_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output sfra_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sfra_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count overflow");

endmodule

@@ rtl/sfra_back.sv @@
// sfra_back: walks each queued job one result per cycle into the output register, while it is empty or popped
// depends on sfra_pkg
module sfra_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  sfra_pkg::t_job      i_job,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output sfra_pkg::t_out_item o_item
);

    localparam int LW = sfra_pkg::LEN_W;

    logic [LW-1:0]       r_idx, n_idx, total;
    sfra_pkg::t_out_item r_out, res;
    logic                r_out_valid, n_out_valid;
    logic                load, last;

    assign load    = !i_q_empty && (!r_out_valid || i_pop);
    assign total   = i_job.cnt + LW'(i_job.eos);
    assign last    = (r_idx + LW'(1) == total);
    assign o_q_pop = load && last;
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        res = '0;
        if (r_idx < i_job.cnt) begin
            for (int i = 0; i < sfra_pkg::LANE_MAX; i++) begin
                if (LW'(i) == r_idx) begin
                    res.out_byte = i_job.bytes[i];
                end
            end
            res.byte_valid = 1'b1;
        end else begin
            res.string_end = 1'b1;
        end
        res.last_of_run = last;

        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (load) begin
            n_idx       = last ? '0 : r_idx + LW'(1);
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.string_end |-> r_out.last_of_run && !r_out.byte_valid)
        else $error("end marker must close its run and carry no byte");

    a_idx_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> !i_q_empty)
        else $error("job index advanced with no job at the queue head");

endmodule

@@ rtl/stream_find_replace_all_top.sv @@
// stream_find_replace_all_top: byte-stream find-and-replace-all, top level
// config registers plus front, job queue and back; depends on sfra_pkg,
// sfra_front, sfra_queue, sfra_back
//
// path: an accepted item that makes results is written into the job queue; its first
//   result is then registered into the output register, from which it can be popped
// throughput: one item per cycle while each item makes at most one result and results
//   are popped; an item making several results (replacement run or flush) holds the
//   back, and the job queue (two entries by default) fills, raising full until it drains
// reset: synchronous, active low; clears window fill, queue, output valid and
//   config to pattern_len 1, others 0; window bytes are undefined until written
module stream_find_replace_all_top #(
    parameter int PATTERN_MAX = sfra_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = sfra_pkg::REPLACE_MAX_DEF,
    parameter int QUEUE_DEPTH = sfra_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input side
    input  logic                               push,
    output logic                               full,
    input  sfra_pkg::t_in_item                 i_in_item,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output sfra_pkg::t_out_item                o_out_item,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfra_pkg::REG_INDEX_W-1:0]   i_cfg_index,
    input  logic [sfra_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int LW = sfra_pkg::LEN_W;

    sfra_pkg::t_cfg r_cfg;
    sfra_pkg::t_job front_job, head_job;
    logic           front_push, q_full, q_empty, q_pop;

    // config writes always land at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes     <= '0;
            r_cfg.pattern_len       <= sfra_pkg::PATTERN_LEN_RST;
            r_cfg.replacement_bytes <= '0;
            r_cfg.replacement_len   <= '0;
        end else if (i_cfg_valid) begin
            case (sfra_pkg::t_reg_index'(i_cfg_index))
                sfra_pkg::REG_PATTERN_BYTES: begin
                    r_cfg.pattern_bytes <= i_cfg_data;
                end
                sfra_pkg::REG_PATTERN_LEN: begin
                    r_cfg.pattern_len <= i_cfg_data[LW-1:0];
                end
                sfra_pkg::REG_REPLACE_BYTES: begin
                    r_cfg.replacement_bytes <= i_cfg_data;
                end
                sfra_pkg::REG_REPLACE_LEN: begin
                    r_cfg.replacement_len <= i_cfg_data[LW-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // the front takes an item whenever the job queue has room
    assign full = q_full;

    // front: window update and classification, one item per cycle while the job queue has room
    sfra_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .REPLACE_MAX (REPLACE_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_q_push (front_push),
        .o_q_job  (front_job)
    );

    // decouples classification from result serialization
    sfra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    // back: one result per cycle into the output register while it is empty or popped
    sfra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out_item)
    );

endmodule

@@ sim/tb.sv @@
// tb: self-checking bench for stream_find_replace_all_top
// drives byte strings through the queue ports and writes the config registers, predicts the edited stream in place
// depends on sfra_pkg and the top-level rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfra_pkg::*;

    localparam int WIN_MAX     = PATTERN_MAX_DEF;
    localparam int REP_MAX     = REPLACE_MAX_DEF;
    localparam int HOLD_AT     = 150;    // result count at which the receiver backs off
    localparam int HOLD_CYCLES = 200;    // long enough to fill the job queue and raise full
    localparam int SETTLE      = 10;     // margin after the last result for items that answer nothing
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 24;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;

    // dut inputs, all known from time zero
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    t_in_item               i_in_item   = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [REG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;

    // predictor copy of the config registers, reset values
    logic [CFG_W-1:0] pat_bytes = '0;
    logic [LEN_W-1:0] pat_len   = PATTERN_LEN_RST;
    logic [CFG_W-1:0] rep_bytes = '0;
    logic [LEN_W-1:0] rep_len   = '0;

    // predictor copy of the unresolved-byte window, oldest first
    logic [BYTE_W-1:0] win_bytes [WIN_MAX];
    int unsigned       win_fill = 0;

    t_in_item  pending_chars [$];   // source items not yet offered
    t_out_item due_results   [$];   // edited-stream results still owed by the block

    t_idle_mode send_mode = IDLE_NONE;
    t_idle_mode recv_mode = IDLE_NONE;
    int unsigned send_gap  = 0;
    int unsigned recv_gap  = 0;
    int unsigned hold_left = 0;

    int items_taken  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int hits         = 0;
    int flushes      = 0;
    int err_count    = 0;

    stream_find_replace_all_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // zero length acts as one, anything past the window size saturates
    function automatic int unsigned eff_pat_len();
        if (pat_len == 0) return 1;
        if (pat_len > WIN_MAX) return WIN_MAX;
        return pat_len;
    endfunction

    function automatic int unsigned eff_rep_len();
        if (rep_len > REP_MAX) return REP_MAX;
        return rep_len;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_char(int unsigned k);
        return pat_bytes[BYTE_W*k +: BYTE_W];
    endfunction

    function automatic t_out_item char_result(logic [BYTE_W-1:0] ch);
        t_out_item r;
        r            = '0;
        r.out_byte   = ch;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic void shift_window(int unsigned n);
        int unsigned k;
        if (n >= win_fill) begin
            win_fill = 0;
        end else begin
            for (k = 0; k < win_fill - n; k++) win_bytes[k] = win_bytes[k + n];
            win_fill = win_fill - n;
        end
    endfunction

    // works out the results of one accepted source item and queues them
    function automatic void predict_edit(t_in_item it);
        t_out_item   run [$];
        t_out_item   marker;
        int unsigned plen;
        int unsigned drop;
        int unsigned k;
        bit          hit;
        plen = eff_pat_len();
        if (win_fill > WIN_MAX - 1) win_fill = WIN_MAX - 1;
        if (it.end_of_string) begin
            // flush what is left, then the end marker
            for (k = 0; k < win_fill; k++) run.push_back(char_result(win_bytes[k]));
            marker            = '0;
            marker.string_end = 1'b1;
            run.push_back(marker);
            win_fill = 0;
            flushes++;
        end else begin
            win_bytes[win_fill] = it.in_byte;
            win_fill++;
            if (win_fill > plen) begin
                // window outgrew a shortened pattern: pass the oldest bytes, no compare
                drop = win_fill - plen + 1;
                for (k = 0; k < drop; k++) run.push_back(char_result(win_bytes[k]));
                shift_window(drop);
            end else if (win_fill == plen) begin
                hit = 1'b1;
                for (k = 0; k < plen; k++) if (win_bytes[k] != pat_char(k)) hit = 1'b0;
                if (hit) begin
                    for (k = 0; k < eff_rep_len(); k++)
                        run.push_back(char_result(rep_bytes[BYTE_W*k +: BYTE_W]));
                    win_fill = 0;
                    hits++;
                end else begin
                    run.push_back(char_result(win_bytes[0]));
                    shift_window(1);
                end
            end
        end
        if (run.size() != 0) run[run.size() - 1].last_of_run = 1'b1;
        for (k = 0; k < run.size(); k++) due_results.push_back(run[k]);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            $error("unexpected result %h", got);
            err_count++;
            return;
        end
        want = due_results.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            err_count++;
        end
        if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
            err_count++;
        end
        if (got.string_end !== want.string_end) begin
            $error("string_end: expected %b, got %b", want.string_end, got.string_end);
            err_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
            err_count++;
        end
    endfunction

    // none never idles; light mostly no gap, some short ones, a few long ones; heavy idles more often
    function automatic int unsigned pick_gap(t_idle_mode mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (mode == IDLE_NONE) return 0;
        if (mode == IDLE_LIGHT && roll < 65) return 0;
        if (mode == IDLE_HEAVY && roll < 35) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // driver: offers pending items, predicts each one as it is accepted
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            // holding while full keeps the same request on the port
            if (push) begin
                predict_edit(i_in_item);
                items_taken++;
            end
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                push      <= 1'b1;
                i_in_item <= pending_chars.pop_front();
                send_gap  = pick_gap(send_mode);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: pops results with random stalls and one long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_out_item);
                results_seen++;
                // long back-off while the sender keeps going, so full has to rise
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
                else recv_gap = pick_gap(recv_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic void queue_char(logic [BYTE_W-1:0] ch);
        t_in_item it;
        it.in_byte       = ch;
        it.end_of_string = 1'b0;
        pending_chars.push_back(it);
    endfunction

    // the byte travels along with the end flag and must be ignored
    function automatic void queue_end(logic [BYTE_W-1:0] junk);
        t_in_item it;
        it.in_byte       = junk;
        it.end_of_string = 1'b1;
        pending_chars.push_back(it);
    endfunction

    // small alphabet mixed in so patterns overlap themselves and the text
    function automatic logic [CFG_W-1:0] rand_pattern();
        logic [CFG_W-1:0] pb;
        int unsigned      k;
        for (k = 0; k < WIN_MAX; k++)
            pb[BYTE_W*k +: BYTE_W] = $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 1))
                                                          : 8'($urandom_range(0, 255));
        return pb;
    endfunction

    task automatic write_reg(t_reg_index idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PATTERN_BYTES: pat_bytes = val;
            REG_PATTERN_LEN:   pat_len   = val[LEN_W-1:0];
            REG_REPLACE_BYTES: rep_bytes = val;
            REG_REPLACE_LEN:   rep_len   = val[LEN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // everything offered and answered, then time for items that answer nothing
    task automatic drain_block();
        while (pending_chars.size() != 0 || push || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // sequence: reset, directed strings, random phases, wrap-up
    // ---------------------------------------------------------------
    initial begin : stimulus
        int unsigned      ph;
        int unsigned      k;
        int unsigned      added;
        int unsigned      roll;
        int unsigned      plen;
        int unsigned      cut;
        int unsigned      bad;
        logic [BYTE_W-1:0] ch;
        logic [LEN_W-1:0] plen_w;
        logic [LEN_W-1:0] rlen_w;
        logic [CFG_W-1:0] pb_w;
        logic [CFG_W-1:0] rb_w;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_mode = IDLE_LIGHT;
        recv_mode = IDLE_LIGHT;

        // reset config: one-byte pattern 00, empty replacement, so 00 vanishes
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(8'h00);
        queue_end(8'hFF);
        drain_block();

        // full-width pattern and replacement: one match, then a longest flush
        write_reg(REG_PATTERN_BYTES, 64'h807F_01FE_00FF_AA55);
        write_reg(REG_PATTERN_LEN,   64'd8);
        write_reg(REG_REPLACE_BYTES, 64'hFF00_C33C_0102_7EE7);
        write_reg(REG_REPLACE_LEN,   64'd8);
        for (k = 0; k < WIN_MAX; k++) queue_char(pat_char(k));
        for (k = 0; k < WIN_MAX - 1; k++) queue_char(pat_char(k));
        queue_end(8'h00);
        drain_block();

        // shorten the pattern with bytes still in the window
        for (k = 0; k < 4; k++) queue_char(pat_char(k));
        drain_block();
        write_reg(REG_PATTERN_LEN, 64'd2);
        queue_char(8'h55);
        queue_char(8'hAA);
        queue_end(8'h80);
        drain_block();

        // random phases, each with its own setting; some end mid-string
        for (ph = 0; ph < PHASES; ph++) begin
            plen_w = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
            rlen_w = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
            pb_w   = rand_pattern();
            rb_w   = {$urandom, $urandom};
            send_mode = t_idle_mode'($urandom_range(0, 2));
            recv_mode = t_idle_mode'($urandom_range(0, 2));
            case (ph)
                0: begin
                    plen_w = 4'd1;  rlen_w = 4'd0;
                    send_mode = IDLE_NONE;
                    recv_mode = IDLE_NONE;
                end
                1: begin
                    plen_w = 4'd8;  rlen_w = 4'd8;
                    pb_w   = '1;    rb_w   = '0;
                    send_mode = IDLE_NONE;
                    recv_mode = IDLE_HEAVY;
                end
                2: begin
                    plen_w = 4'd0;  rlen_w = 4'd15;
                end
                3: begin
                    plen_w = 4'd15; rlen_w = 4'd1;
                    pb_w   = '0;    rb_w   = '1;
                end
                4: plen_w = 4'd9;
                default: ;
            endcase
            write_reg(REG_PATTERN_BYTES, pb_w);
            write_reg(REG_PATTERN_LEN,   64'(plen_w));
            write_reg(REG_REPLACE_BYTES, rb_w);
            write_reg(REG_REPLACE_LEN,   64'(rlen_w));

            // mostly copies of the pattern, some damaged or cut short, plus noise
            plen  = eff_pat_len();
            added = 0;
            while (added < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 7) begin
                    queue_end(8'($urandom_range(0, 255)));
                    added++;
                end else if (roll < 45) begin
                    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, plen) : plen;
                    bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cut - 1) : WIN_MAX;
                    for (k = 0; k < cut; k++) begin
                        ch = pat_char(k);
                        if (k == bad) ch = ch ^ (8'h01 << $urandom_range(0, 7));
                        queue_char(ch);
                        added++;
                    end
                end else if (roll < 75) begin
                    queue_char(pat_char($urandom_range(0, plen - 1)));
                    added++;
                end else begin
                    queue_char(8'($urandom_range(0, 255)));
                    added++;
                end
            end
            if ($urandom_range(0, 1) == 1) queue_end(8'($urandom_range(0, 255)));
            drain_block();
        end

        // late stray results would show up as unexpected during this wait
        repeat (2 * SETTLE) @(posedge i_clk);

        $display("covered %0d source items under %0d register writes across %0d phases",
                 items_taken, cfg_writes, PHASES + 3);
        $display("checked %0d results: %0d pattern hits, %0d string ends",
                 results_seen, hits, flushes);
        if (err_count == 0 && due_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // run limit, well above the slowest legal run
    initial begin
        #8_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

@@ stream_find_replace_all_top.f @@
rtl/sfra_pkg.sv
rtl/sfra_front.sv
rtl/sfra_queue.sv
rtl/sfra_back.sv
rtl/stream_find_replace_all_top.sv
sim/tb.sv
